@@ src/mh64_pkg.sv @@
// shared types and constants for the murmur 64b hash unit
package mh64_pkg;

  localparam logic [31:0] MultReset = 32'h5bd1e995;
  localparam int unsigned MixShift  = 24;
  localparam int unsigned FinShiftA = 18;
  localparam int unsigned FinShiftB = 22;
  localparam int unsigned FinShiftC = 17;
  localparam int unsigned FinShiftD = 19;

  localparam logic RegSeed = 1'b0;
  localparam logic RegMult = 1'b1;

  // one datapath operation per cycle, each uses the shared multiplier at most once
  typedef enum logic [3:0] {
    OP_NONE = 4'd0,
    OP_LOAD = 4'd1,
    OP_K1   = 4'd2,
    OP_K2   = 4'd3,
    OP_LANE = 4'd4,
    OP_TAIL = 4'd5,
    OP_F1   = 4'd6,
    OP_F2   = 4'd7,
    OP_F3   = 4'd8,
    OP_F4   = 4'd9
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic in_full;   // incoming word has four or more bytes
    logic in_tail;   // incoming word has one to three bytes
    logic in_last;
    logic last_q;    // held item is the last of its message
    logic out_busy;  // result register still occupied this cycle
  } stat_t;

endpackage

@@ src/murmur_hash_64b_unit.sv @@
// top level of the streaming murmur 64b hash unit
//
//  channel  direction  handshake               payload
//  in       input      in_valid_i/in_ready_o   data_word_i, byte_count_i, last_item_i,
//                                              message_length_i
//  out      output     out_valid_o/out_ready_i hash_value_o
//  cfg      input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// one shared 32x32 multiplier orders the work: after a transaction is accepted, a full
// word goes through K1, K2 and LANE, a tail through TAIL, an empty word through none
// a last transaction adds the finalization steps F1 to F4 before the hash is registered
// the result register frees the input side; the next transaction is accepted
// while a hash waits, and finalization stalls only if the previous hash is still held
// reset clears the control state, seed to zero and multiplier to its standard value
module murmur_hash_64b_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_item_i,
  input  logic [31:0] message_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] hash_value_o
);

  mh64_pkg::cmd_t  cmd;
  mh64_pkg::stat_t stat;

  mh64_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mh64_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .data_word_i      (data_word_i),
    .byte_count_i     (byte_count_i),
    .last_item_i      (last_item_i),
    .message_length_i (message_length_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .hash_value_o     (hash_value_o),
    .cmd_i            (cmd),
    .stat_o           (stat)
  );

endmodule

@@ src/mh64_ctrl.sv @@
// sequencer for the murmur 64b hash unit
module mh64_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mh64_pkg::stat_t stat_i,
  output mh64_pkg::cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_K1   = 9'b000000010,
    ST_K2   = 9'b000000100,
    ST_LANE = 9'b000001000,
    ST_TAIL = 9'b000010000,
    ST_F1   = 9'b000100000,
    ST_F2   = 9'b001000000,
    ST_F3   = 9'b010000000,
    ST_F4   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = mh64_pkg::OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = mh64_pkg::OP_LOAD;
          if (stat_i.in_full) begin
            state_d = ST_K1;
          end else if (stat_i.in_tail) begin
            state_d = ST_TAIL;
          end else if (stat_i.in_last) begin
            state_d = ST_F1;
          end
        end
      end
      ST_K1: begin
        cmd_o.op = mh64_pkg::OP_K1;
        state_d  = ST_K2;
      end
      ST_K2: begin
        cmd_o.op = mh64_pkg::OP_K2;
        state_d  = ST_LANE;
      end
      ST_LANE: begin
        cmd_o.op = mh64_pkg::OP_LANE;
        state_d  = stat_i.last_q ? ST_F1 : ST_IDLE;
      end
      ST_TAIL: begin
        cmd_o.op = mh64_pkg::OP_TAIL;
        state_d  = stat_i.last_q ? ST_F1 : ST_IDLE;
      end
      ST_F1: begin
        cmd_o.op = mh64_pkg::OP_F1;
        state_d  = ST_F2;
      end
      ST_F2: begin
        cmd_o.op = mh64_pkg::OP_F2;
        state_d  = ST_F3;
      end
      ST_F3: begin
        cmd_o.op = mh64_pkg::OP_F3;
        state_d  = ST_F4;
      end
      ST_F4: begin
        // wait here until the result register can take the hash
        if (!stat_i.out_busy) begin
          cmd_o.op = mh64_pkg::OP_F4;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/mh64_dp.sv @@
// lanes, config registers, shared multiplier and result register
module mh64_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [63:0]     cfg_data_i,
  input  logic [31:0]     data_word_i,
  input  logic [2:0]      byte_count_i,
  input  logic            last_item_i,
  input  logic [31:0]     message_length_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [63:0]     hash_value_o,
  input  mh64_pkg::cmd_t  cmd_i,
  output mh64_pkg::stat_t stat_o
);

  logic [63:0] seed_q;
  logic [31:0] mult_q;
  logic [31:0] lane1_q, lane2_q, word_q, k_q;
  logic        last_q, next2_q, inside_q;
  logic [63:0] hash_q;
  logic        out_valid_q;

  logic [31:0] tail_mask;
  logic [31:0] mul_a;
  logic [31:0] prod;

  always_comb begin
    case (byte_count_i)
      3'd1:    tail_mask = 32'h0000_00ff;
      3'd2:    tail_mask = 32'h0000_ffff;
      3'd3:    tail_mask = 32'h00ff_ffff;
      default: tail_mask = 32'hffff_ffff;
    endcase
  end

  assign stat_o.in_full  = byte_count_i[2];
  assign stat_o.in_tail  = !byte_count_i[2] && (byte_count_i != 3'd0);
  assign stat_o.in_last  = last_item_i;
  assign stat_o.last_q   = last_q;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  // operand select for the one shared multiplier
  always_comb begin
    case (cmd_i.op)
      mh64_pkg::OP_K1:   mul_a = word_q;
      mh64_pkg::OP_K2:   mul_a = k_q ^ (k_q >> mh64_pkg::MixShift);
      mh64_pkg::OP_LANE: mul_a = next2_q ? lane2_q : lane1_q;
      mh64_pkg::OP_TAIL: mul_a = lane2_q ^ word_q;
      mh64_pkg::OP_F1:   mul_a = lane1_q ^ (lane2_q >> mh64_pkg::FinShiftA);
      mh64_pkg::OP_F2:   mul_a = lane2_q ^ (lane1_q >> mh64_pkg::FinShiftB);
      mh64_pkg::OP_F3:   mul_a = lane1_q ^ (lane2_q >> mh64_pkg::FinShiftC);
      mh64_pkg::OP_F4:   mul_a = lane2_q ^ (lane1_q >> mh64_pkg::FinShiftD);
      default:           mul_a = 32'd0;
    endcase
  end

  // only the low 32 bits of the product are kept
  assign prod = mul_a * mult_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= 64'd0;
      mult_q      <= mh64_pkg::MultReset;
      last_q      <= 1'b0;
      next2_q     <= 1'b0;
      inside_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == mh64_pkg::RegSeed) begin
          seed_q <= cfg_data_i;
        end else begin
          mult_q <= cfg_data_i[31:0];
        end
      end
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        mh64_pkg::OP_LOAD: begin
          last_q   <= last_item_i;
          inside_q <= 1'b1;
          if (!inside_q) begin
            next2_q <= 1'b0;
          end
        end
        mh64_pkg::OP_LANE: begin
          next2_q <= !next2_q;
        end
        mh64_pkg::OP_F4: begin
          out_valid_q <= 1'b1;
          inside_q    <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      mh64_pkg::OP_LOAD: begin
        word_q <= data_word_i & tail_mask;
        if (!inside_q) begin
          // first transaction of a message seeds both lanes
          lane1_q <= seed_q[31:0] ^ message_length_i;
          lane2_q <= seed_q[63:32];
        end
      end
      mh64_pkg::OP_K1,
      mh64_pkg::OP_K2: begin
        k_q <= prod;
      end
      mh64_pkg::OP_LANE: begin
        if (next2_q) begin
          lane2_q <= prod ^ k_q;
        end else begin
          lane1_q <= prod ^ k_q;
        end
      end
      mh64_pkg::OP_TAIL,
      mh64_pkg::OP_F2: begin
        lane2_q <= prod;
      end
      mh64_pkg::OP_F1,
      mh64_pkg::OP_F3: begin
        lane1_q <= prod;
      end
      mh64_pkg::OP_F4: begin
        hash_q <= {lane1_q, prod};
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

endmodule
